// ----- hdl/u16d_pkg.sv -----
// Shared types, constants and classification helpers for the UTF-16 decoder.
package u16d_pkg;

  localparam logic [15:0] HIGH_BASE = 16'hD800;
  localparam logic [15:0] LOW_BASE  = 16'hDC00;
  localparam logic [15:0] SURR_END  = 16'hE000;
  localparam logic [20:0] PLANE_ONE = 21'h10000;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [15:0] code_unit;
    logic        stream_end;
  } unit_word_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic        from_pair;
    logic        run_last;
    logic        output_end;
  } cp_word_t;

  // Work for the back end: one result (point_a), or two results
  // (point_a, then unit_b unchanged).
  typedef struct packed {
    logic        two;
    logic [20:0] point_a;
    logic        pair_a;
    logic [15:0] unit_b;
    logic        stream_end;
  } job_t;

  function automatic logic is_high(input logic [15:0] u);
    return (u >= HIGH_BASE) && (u < LOW_BASE);
  endfunction

  function automatic logic is_low(input logic [15:0] u);
    return (u >= LOW_BASE) && (u < SURR_END);
  endfunction

endpackage

// ----- hdl/u16d_front.sv -----
// Front end: accepts code units, tracks the pending high surrogate and builds jobs.
module u16d_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              unit_valid,
  output logic              unit_ready,
  input  u16d_pkg::unit_word_t unit_word,
  input  logic              queue_full,
  output logic              push,
  output u16d_pkg::job_t    job
);
  import u16d_pkg::*;

  logic       pending;
  logic       pending_next;
  logic [9:0] pending_bits;
  logic [9:0] pending_bits_next;
  logic       accept;
  logic       hi;
  logic       lo;
  logic       last;
  logic [15:0] u;
  logic [20:0] pair_point;
  logic [20:0] held_point;

  assign unit_ready = !queue_full;
  assign accept     = unit_valid && unit_ready;
  assign u          = unit_word.code_unit;
  assign last       = unit_word.stream_end;
  assign hi         = is_high(u);
  assign lo         = is_low(u);
  assign pair_point = {1'b0, pending_bits, u[9:0]} + PLANE_ONE;
  assign held_point = {5'b0, HIGH_BASE | {6'b0, pending_bits}};

  always_comb begin
    push              = 1'b0;
    job.two           = 1'b0;
    job.point_a       = {5'b0, u};
    job.pair_a        = 1'b0;
    job.unit_b        = u;
    job.stream_end    = last;
    pending_next      = pending;
    pending_bits_next = pending_bits;
    if (accept) begin
      pending_next      = hi && !last;
      pending_bits_next = u[9:0];
      if (pending && lo) begin
        push        = 1'b1;
        job.point_a = pair_point;
        job.pair_a  = 1'b1;
      end else if (pending) begin
        push        = 1'b1;
        job.point_a = held_point;
        job.two     = !(hi && !last);
      end else begin
        push = !(hi && !last);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending      <= 1'b0;
      pending_bits <= '0;
    end else begin
      pending      <= pending_next;
      pending_bits <= pending_bits_next;
    end
  end

endmodule

// ----- hdl/u16d_queue.sv -----
// Short job queue between the front end and the back end.
module u16d_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  u16d_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output u16d_pkg::job_t head_job
);
  import u16d_pkg::*;

  job_t                   entries [QUEUE_DEPTH];
  logic [QUEUE_IDX_W-1:0] wr_ptr;
  logic [QUEUE_IDX_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   do_push;
  logic                   do_pop;

  assign full       = count == QUEUE_CNT_W'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_job   = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hdl/u16d_back.sv -----
// Back end: expands each job into one or two result words in an output register.
module u16d_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  u16d_pkg::job_t     head_job,
  output logic               pop,
  output logic               cp_valid,
  input  logic               cp_ready,
  output u16d_pkg::cp_word_t cp_word
);
  import u16d_pkg::*;

  logic     phase;
  logic     phase_next;
  logic     cp_valid_next;
  cp_word_t cp_word_next;
  logic     load;
  logic     first_of_two;

  assign load         = !cp_valid || cp_ready;
  assign first_of_two = head_job.two && !phase;

  always_comb begin
    pop           = 1'b0;
    phase_next    = phase;
    cp_valid_next = cp_valid;
    cp_word_next  = cp_word;
    if (load) begin
      cp_valid_next = head_valid;
      if (head_valid) begin
        if (first_of_two) begin
          phase_next              = 1'b1;
          cp_word_next.code_point = head_job.point_a;
          cp_word_next.from_pair  = 1'b0;
          cp_word_next.run_last   = 1'b0;
          cp_word_next.output_end = 1'b0;
        end else begin
          pop                     = 1'b1;
          phase_next              = 1'b0;
          cp_word_next.code_point = phase ? {5'b0, head_job.unit_b} : head_job.point_a;
          cp_word_next.from_pair  = phase ? 1'b0 : head_job.pair_a;
          cp_word_next.run_last   = 1'b1;
          cp_word_next.output_end = head_job.stream_end;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= 1'b0;
      cp_valid <= 1'b0;
    end else begin
      phase    <= phase_next;
      cp_valid <= cp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cp_word <= cp_word_next;
  end

endmodule

// ----- hdl/utf16_to_code_point_decoder_core.sv -----
// Top level of the UTF-16 surrogate pair decoder.
//
//   channel   direction  handshake              word
//   unit      in         unit_valid/unit_ready  unit_word (code_unit, stream_end)
//   cp        out        cp_valid/cp_ready      cp_word (code_point, from_pair, run_last,
//                                               output_end)
//
// The back end sends one word per cycle while cp_ready allows it, so an item with two
// results gives two words in turn and one with none gives no word.
// An accepted unit's job is registered in the four-entry queue, then in the output register.
// Reset clears the pending surrogate, empties the queue and clears cp_valid; cp_word is not reset.
// The front end stalls only when the queue is full; the back end stalls on cp_ready.
module utf16_to_code_point_decoder_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 unit_valid,
  output logic                 unit_ready,
  input  u16d_pkg::unit_word_t unit_word,
  output logic                 cp_valid,
  input  logic                 cp_ready,
  output u16d_pkg::cp_word_t   cp_word
);
  import u16d_pkg::*;

  logic queue_full;
  logic push;
  job_t push_job;
  logic pop;
  logic head_valid;
  job_t head_job;

  u16d_front u_front (
    .clk        (clk),
    .rst        (rst),
    .unit_valid (unit_valid),
    .unit_ready (unit_ready),
    .unit_word  (unit_word),
    .queue_full (queue_full),
    .push       (push),
    .job        (push_job)
  );

  u16d_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  u16d_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .cp_valid   (cp_valid),
    .cp_ready   (cp_ready),
    .cp_word    (cp_word)
  );

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    cp_valid && cp_word.output_end |-> cp_word.run_last)
    else $error("Stream end word is not the last word of its item.");

  a_pair_range: assert property (@(posedge clk) disable iff (rst)
    cp_valid && cp_word.from_pair |-> (cp_word.code_point[20:16] != 5'd0) &&
      (cp_word.code_point <= 21'h10FFFF))
    else $error("Combined code point out of the supplementary range.");

  a_unpaired_range: assert property (@(posedge clk) disable iff (rst)
    cp_valid && !cp_word.from_pair |-> cp_word.code_point[20:16] == 5'd0)
    else $error("Unpaired word wider than one code unit.");

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !queue_full)
    else $error("Job pushed into a full queue.");

endmodule
